// ----- design/sset_pkg.sv -----
// Shared types and constants for the sorted unique set block.
// Used by sset_ctrl, sset_datapath and sorted_unique_set; depends on nothing.
`default_nettype none

package sset_pkg;

    // Default depth of the set and the most results a dump emits.
    localparam int DEF_CAPACITY = 16;
    localparam int MAX_RESULTS  = 16;

    // Field widths of the request and result channels.
    localparam int OP_W     = 2;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 4;
    localparam int FILL_W   = 5;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_op;   // capture the accepted request
        logic exec;      // compare, update the cell chain, load the result
        logic advance;   // step a dump to the next entry
    } sset_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic op_none;   // captured request has the unused opcode
        logic res_last;  // result register holds the final result
    } sset_stat_t;

endpackage

`default_nettype wire

// ----- design/sorted_unique_set.sv -----
// Top level of the sorted unique set: controller plus cell-chain datapath.
// Depends on sset_pkg, sset_ctrl and sset_datapath.
`default_nettype none

// The block holds up to CAPACITY distinct signed 32-bit values in ascending
// order in a chain of registers. A request with op insert places the value at
// its sorted position (status done with that position, duplicate with the
// position of the existing entry, or full when no room is left); op remove
// deletes a matching value and closes the gap (status not found when absent);
// op dump streams the stored values in order, one result per entry with its
// position, flagging the final one with last, and at most sixteen results; a
// dump of an empty set gives a single empty result. Opcode three is dropped
// without a result. Every result carries the fill after the operation. One
// request is handled at a time: a request is taken in the idle cycle, the
// next cycle compares the operand against all cells at once and updates the
// chain, and the result is offered from a register in the cycle after that.
// No clearing pass is needed after reset.
module sorted_unique_set
    import sset_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [OP_W-1:0]            s_op,
    input  wire logic signed [VAL_W-1:0]    s_value,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [STATUS_W-1:0]             m_status,
    output logic signed [VAL_W-1:0]         m_entry_value,
    output logic [POS_W-1:0]                m_position,
    output logic [FILL_W-1:0]               m_fill,
    output logic                            m_last
);

    // Commands flow from the controller to the datapath, status flows back.
    sset_cmd_t  cmd;
    sset_stat_t stat;

    // The controller owns both handshakes and steps each request through
    // capture, execute and, unless it has the unused opcode, send.
    sset_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // The datapath holds the sorted cells, the entry count and the result
    // register that drives the result channel.
    sset_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_op          (s_op),
        .s_value       (s_value),
        .m_status      (m_status),
        .m_entry_value (m_entry_value),
        .m_position    (m_position),
        .m_fill        (m_fill),
        .m_last        (m_last)
    );

endmodule

`default_nettype wire

// ----- design/sset_ctrl.sv -----
// Sequencing state machine of the sorted unique set.
// Depends on sset_pkg for the command and status structs.
`default_nettype none

module sset_ctrl
    import sset_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  wire sset_stat_t stat,
    output sset_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_SEND = 3'b100
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_SEND);

    always_comb begin
        cmd         = '0;
        cmd.load_op = s_valid && s_ready;
        cmd.exec    = (state_reg == S_EXEC);
        cmd.advance = m_valid && m_ready && !stat.res_last;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = stat.op_none ? S_IDLE : S_SEND;
            end
            S_SEND: begin
                if (m_ready && stat.res_last) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    // A new request is never taken while a result is being offered.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request accepted while a result is pending");

    // A captured request is always processed in the following cycle.
    a_exec_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_op |=> cmd.exec)
        else $error("captured request was not executed");

    // The final result returns the controller to idle.
    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && stat.res_last) |=> s_ready)
        else $error("controller did not return to idle after the last result");
`endif

endmodule

`default_nettype wire

// ----- design/sset_datapath.sv -----
// Cell chain, compare logic and result register of the sorted unique set.
// Depends on sset_pkg for widths, codes and the command and status structs.
`default_nettype none

module sset_datapath
    import sset_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire sset_cmd_t                  cmd,
    output sset_stat_t                      stat,
    input  wire logic [OP_W-1:0]            s_op,
    input  wire logic signed [VAL_W-1:0]    s_value,
    output logic [STATUS_W-1:0]             m_status,
    output logic signed [VAL_W-1:0]         m_entry_value,
    output logic [POS_W-1:0]                m_position,
    output logic [FILL_W-1:0]               m_fill,
    output logic                            m_last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int AW = CW + POS_W + 1;

    logic [OP_W-1:0]          op_reg;
    logic signed [VAL_W-1:0]  val_reg;
    logic signed [VAL_W-1:0]  cells_reg [CAPACITY];
    logic signed [VAL_W-1:0]  cells_next [CAPACITY];
    logic [CW-1:0]            count_reg, count_next;
    logic [IW-1:0]            idx_reg, idx_next;
    logic [STATUS_W-1:0]      res_status_reg, res_status_next;
    logic signed [VAL_W-1:0]  res_value_reg, res_value_next;
    logic [POS_W-1:0]         res_pos_reg, res_pos_next;
    logic                     res_last_reg, res_last_next;

    logic [CAPACITY-1:0]      lt;
    logic [CAPACITY-1:0]      eq;
    logic [CAPACITY-1:0]      bnd;
    logic [IW-1:0]            eq_pos;
    logic [IW-1:0]            ins_pos;
    logic                     found;
    logic                     full;
    logic [IW+POS_W-1:0]      pos_ext;
    logic [IW+POS_W-1:0]      idx_ext;
    logic [CW+FILL_W-1:0]     fill_ext;
    logic [IW-1:0]            nidx;
    logic                     next_last;

    // Parallel compare of every live cell against the captured operand.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            lt[i] = (CW'(i) < count_reg) && (cells_reg[i] < val_reg);
            eq[i] = (CW'(i) < count_reg) && (cells_reg[i] == val_reg);
        end
        bnd[0] = !lt[0];
        for (int i = 1; i < CAPACITY; i++) begin
            bnd[i] = lt[i-1] && !lt[i];
        end
    end

    always_comb begin
        eq_pos  = '0;
        ins_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (eq[i]) begin
                eq_pos = eq_pos | IW'(i);
            end
            if (bnd[i]) begin
                ins_pos = ins_pos | IW'(i);
            end
        end
    end

    assign found = |eq;
    assign full  = (count_reg == CW'(CAPACITY));

    // Dump stepping: index of the next entry and whether it ends the dump.
    assign nidx      = idx_reg + IW'(1);
    assign next_last = (AW'(nidx) + AW'(1) == AW'(count_reg)) ||
                       (AW'(nidx) == AW'(MAX_RESULTS - 1));

    always_comb begin
        cells_next      = cells_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_pos_next    = res_pos_reg;
        res_last_next   = res_last_reg;
        pos_ext         = '0;
        idx_ext         = '0;

        if (cmd.exec) begin
            res_value_next = val_reg;
            res_last_next  = 1'b1;
            res_pos_next   = '0;
            case (op_reg)
                OP_INSERT: begin
                    if (found) begin
                        res_status_next = ST_DUPLICATE;
                        pos_ext         = {{POS_W{1'b0}}, eq_pos};
                        res_pos_next    = pos_ext[POS_W-1:0];
                    end else if (full) begin
                        res_status_next = ST_FULL;
                    end else begin
                        res_status_next = ST_DONE;
                        pos_ext         = {{POS_W{1'b0}}, ins_pos};
                        res_pos_next    = pos_ext[POS_W-1:0];
                        count_next      = count_reg + CW'(1);
                        if (!lt[0]) begin
                            cells_next[0] = val_reg;
                        end
                        for (int i = 1; i < CAPACITY; i++) begin
                            if (!lt[i]) begin
                                if (lt[i-1]) begin
                                    cells_next[i] = val_reg;
                                end else begin
                                    cells_next[i] = cells_reg[i-1];
                                end
                            end
                        end
                    end
                end
                OP_REMOVE: begin
                    if (!found) begin
                        res_status_next = ST_NOT_FOUND;
                    end else begin
                        res_status_next = ST_DONE;
                        pos_ext         = {{POS_W{1'b0}}, eq_pos};
                        res_pos_next    = pos_ext[POS_W-1:0];
                        count_next      = count_reg - CW'(1);
                        for (int i = 0; i < CAPACITY - 1; i++) begin
                            if (!lt[i]) begin
                                cells_next[i] = cells_reg[i+1];
                            end
                        end
                    end
                end
                OP_DUMP: begin
                    idx_next = '0;
                    if (count_reg == '0) begin
                        res_status_next = ST_EMPTY;
                        res_value_next  = '0;
                    end else begin
                        res_status_next = ST_DONE;
                        res_value_next  = cells_reg[0];
                        res_last_next   = (count_reg == CW'(1));
                    end
                end
                default: begin
                    res_status_next = ST_DONE;
                end
            endcase
        end else if (cmd.advance) begin
            idx_next        = nidx;
            idx_ext         = {{POS_W{1'b0}}, nidx};
            res_status_next = ST_DONE;
            res_value_next  = cells_reg[nidx];
            res_pos_next    = idx_ext[POS_W-1:0];
            res_last_next   = next_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_op) begin
            op_reg  <= s_op;
            val_reg <= s_value;
        end
        cells_reg      <= cells_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_pos_reg    <= res_pos_next;
        idx_reg        <= idx_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            res_last_reg <= 1'b1;
        end else begin
            count_reg    <= count_next;
            res_last_reg <= res_last_next;
        end
    end

    assign fill_ext      = {{FILL_W{1'b0}}, count_reg};
    assign m_status      = res_status_reg;
    assign m_entry_value = res_value_reg;
    assign m_position    = res_pos_reg;
    assign m_fill        = fill_ext[FILL_W-1:0];
    assign m_last        = res_last_reg;

    always_comb begin
        stat          = '0;
        stat.op_none  = (op_reg == OP_NONE);
        stat.res_last = res_last_reg;
    end

`ifndef SYNTH
    // The fill count never exceeds the number of cells.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // Stored values are distinct, so at most one live cell matches.
    a_unique_match: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> $onehot0(eq))
        else $error("operand matches more than one stored entry");

    // An accepted insert grows the set by exactly one entry.
    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && op_reg == OP_INSERT && !found && !full)
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the set by one");

    // A dump never steps beyond the entry flagged as last.
    a_no_step_past_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.advance |-> !res_last_reg)
        else $error("dump advanced past its final result");
`endif

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for sorted_unique_set: insert, remove and dump requests, with random idling on both
// channels, checked against a cycle-free behavioral model of the ordered set.
// Depends on sset_pkg and the sorted_unique_set RTL.

module testbench;
    import sset_pkg::*;

    // The block is built with its default depth, so the model uses the same one.
    localparam int SET_DEPTH   = DEF_CAPACITY;
    // Cycles to let pass once the last expected result has come, so that a stray
    // result after the final one would still be seen.
    localparam int TAIL_CYCLES = 40;

    // One result as it appears on the result channel.
    typedef struct {
        logic [STATUS_W-1:0]     status;
        logic signed [VAL_W-1:0] entry_value;
        logic [POS_W-1:0]        position;
        logic [FILL_W-1:0]       fill;
        logic                    last;
    } set_result_t;

    // Keeps its own copy of the ordered set, works out the results that each
    // accepted request causes, and compares the results that come back.
    class sorted_set_tracker;
        logic signed [VAL_W-1:0] held[SET_DEPTH];
        int                      held_count;
        set_result_t             awaited[$];
        int                      faults;

        function new();
            held_count = 0;
            faults     = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Index of the first held value that is not below v.
        function int lower_slot(logic signed [VAL_W-1:0] v);
            int i;
            i = 0;
            while (i < held_count && held[i] < v) i++;
            return i;
        endfunction

        function void await_result(logic [STATUS_W-1:0] status, logic signed [VAL_W-1:0] v,
                                   int pos, int fill, logic last);
            set_result_t r;
            r.status      = status;
            r.entry_value = v;
            r.position    = POS_W'(pos);
            r.fill        = FILL_W'(fill);
            r.last        = last;
            awaited.push_back(r);
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] v);
            int slot;
            int n;
            slot = lower_slot(v);
            case (op)
                OP_INSERT: begin
                    // The duplicate check comes before the full check.
                    if (slot < held_count && held[slot] == v) begin
                        await_result(ST_DUPLICATE, v, slot, held_count, 1'b1);
                    end else if (held_count >= SET_DEPTH) begin
                        await_result(ST_FULL, v, 0, held_count, 1'b1);
                    end else begin
                        for (int i = held_count; i > slot; i--) held[i] = held[i - 1];
                        held[slot] = v;
                        held_count++;
                        await_result(ST_DONE, v, slot, held_count, 1'b1);
                    end
                end
                OP_REMOVE: begin
                    if (slot >= held_count || held[slot] != v) begin
                        await_result(ST_NOT_FOUND, v, 0, held_count, 1'b1);
                    end else begin
                        for (int i = slot; i + 1 < held_count; i++) held[i] = held[i + 1];
                        held_count--;
                        await_result(ST_DONE, v, slot, held_count, 1'b1);
                    end
                end
                OP_DUMP: begin
                    if (held_count == 0) begin
                        await_result(ST_EMPTY, '0, 0, 0, 1'b1);
                    end else begin
                        n = (held_count > MAX_RESULTS) ? MAX_RESULTS : held_count;
                        for (int i = 0; i < n; i++)
                            await_result(ST_DONE, held[i], i, held_count, i == n - 1);
                    end
                end
                default: begin
                    // The unused opcode leaves the set alone and answers nothing.
                end
            endcase
        endfunction

        function void check_result(set_result_t got);
            set_result_t want;
            if (awaited.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result: st %0d val %0d pos %0d fill %0d last %0d",
                             got.status, got.entry_value, got.position, got.fill, got.last);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status || got.entry_value !== want.entry_value ||
                got.position !== want.position || got.fill !== want.fill ||
                got.last !== want.last) begin
                faults++;
                if (faults <= 10) begin
                    $display("mismatch: want st %0d val %0d pos %0d fill %0d last %0d",
                             want.status, want.entry_value, want.position, want.fill,
                             want.last);
                    $display("          got  st %0d val %0d pos %0d fill %0d last %0d",
                             got.status, got.entry_value, got.position, got.fill,
                             got.last);
                end
            end
        endfunction

        // Results still waiting at the end count as failures.
        function int close_out();
            if (awaited.size() != 0) begin
                $display("%0d expected results never arrived", awaited.size());
                faults += awaited.size();
            end
            return faults;
        endfunction
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic [OP_W-1:0]         s_op;
    logic signed [VAL_W-1:0] s_value;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [STATUS_W-1:0]     m_status;
    logic signed [VAL_W-1:0] m_entry_value;
    logic [POS_W-1:0]        m_position;
    logic [FILL_W-1:0]       m_fill;
    logic                    m_last;

    // Chance in a hundred that the sender or the receiver idles in a given cycle.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    sorted_set_tracker tracker;

    sorted_unique_set dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_entry_value (m_entry_value),
        .m_position    (m_position),
        .m_fill        (m_fill),
        .m_last        (m_last)
    );

    // 4 ns clock period.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // The receiver decides at each falling edge whether it takes a result at the
    // next rising edge.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Every result taken at a rising edge goes to the tracker. The values read here
    // are the ones from before the edge, since the block updates them afterwards.
    always @(posedge aclk) begin : watch_results
        set_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.status      = m_status;
            got.entry_value = m_entry_value;
            got.position    = m_position;
            got.fill        = m_fill;
            got.last        = m_last;
            tracker.check_result(got);
        end
    end

    // Offers one request and returns at the falling edge after it was accepted.
    // Valid is only lowered when a gap is actually taken, so a request that follows
    // straight on keeps valid high without a second assignment in the same step.
    task automatic send_request(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] v);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_request(op, v);
        @(negedge aclk);
    endtask

    // Holds the sender off until every expected result has come back. At least one
    // falling edge passes, so the next request never drives valid in the same step.
    task automatic await_drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (tracker.pending() != 0) @(negedge aclk);
    endtask

    // Random requests, mostly on a small pool of operands so that duplicates,
    // matching removes and a full set come up often. The pool holds values near
    // zero, both extremes and full-range values; a fifth of the operands are
    // fresh full-range values that mostly miss. Requests with the unused opcode
    // are sent but not counted.
    task automatic run_phase(input int count, input int sender_pct, input int receiver_pct);
        logic signed [VAL_W-1:0] pool[20];
        logic signed [VAL_W-1:0] v;
        logic [OP_W-1:0]         op;
        int                      sent;
        int                      pick;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        foreach (pool[i]) begin
            pool[i] = $urandom;
            if (i < 6) pool[i] = $signed($urandom_range(20)) - 10;
        end
        pool[6] = 32'sh8000_0000;
        pool[7] = 32'sh7FFF_FFFF;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 48) begin
                op = OP_INSERT;
            end else if (pick < 80) begin
                op = OP_REMOVE;
            end else if (pick < 95) begin
                op = OP_DUMP;
            end else begin
                op = OP_NONE;
            end
            if ($urandom_range(99) < 80) begin
                v = pool[$urandom_range(19)];
            end else begin
                v = $urandom;
            end
            send_request(op, v);
            if (op != OP_NONE) sent++;
        end
    endtask

    initial begin : main_sequence
        logic signed [VAL_W-1:0] v;
        tracker = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_op    = OP_INSERT;
        s_value = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part, with neither side idling.
        // An empty set: a dump gives the single empty result, a remove misses.
        send_request(OP_DUMP, 32'sd77);
        send_request(OP_REMOVE, 32'sd5);
        // Both extremes, then values that land in the middle of the list.
        send_request(OP_INSERT, 32'sh8000_0000);
        send_request(OP_INSERT, 32'sh7FFF_FFFF);
        send_request(OP_INSERT, 32'sd0);
        send_request(OP_INSERT, -32'sd1);
        send_request(OP_INSERT, 32'sd1);
        // A duplicate insert, a remove of an absent value, a remove from the middle.
        send_request(OP_INSERT, 32'sd0);
        send_request(OP_REMOVE, 32'sd7);
        send_request(OP_REMOVE, 32'sd0);
        send_request(OP_DUMP, '0);
        // The unused opcode must be dropped without a result.
        send_request(OP_NONE, 32'sh5555_5555);
        // Fill the set to capacity with patterns spread over the whole range.
        for (int k = 2; k < 14; k++) begin
            v = 32'sh1111_1111 * k;
            send_request(OP_INSERT, v);
        end
        // A full set rejects a new value, but a duplicate is still reported as one.
        send_request(OP_INSERT, 32'sh0000_0042);
        send_request(OP_INSERT, 32'sh7FFF_FFFF);
        send_request(OP_DUMP, '0);
        // Remove from both ends.
        send_request(OP_REMOVE, 32'sh8000_0000);
        send_request(OP_REMOVE, 32'sh7FFF_FFFF);

        // Random part in three idling regimes. Between them the sender waits for
        // the block to drain completely.
        await_drain();
        run_phase(50, 28, 75);
        await_drain();
        run_phase(50, 75, 28);
        await_drain();
        run_phase(50, 0, 0);

        await_drain();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (tracker.close_out() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #2_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
design/sset_pkg.sv
design/sset_ctrl.sv
design/sset_datapath.sv
design/sorted_unique_set.sv
tb/testbench.sv
